// ----- rtl/core/nvqp_pkg.sv -----
// Shared types, codes and helpers for the NVMe I/O queue pair host block.
package nvqp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 512;

    localparam logic [18:0] DB_BASE       = 19'h01000;
    localparam logic [1:0]  IO_QID        = 2'd1;
    localparam logic [23:0] TIMEOUT_RESET = 24'd10000000;
    localparam logic [7:0]  NVM_OPC_WRITE = 8'h01;
    localparam logic [7:0]  NVM_OPC_READ  = 8'h02;

    typedef enum logic [1:0] {
        OP_READ       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_COMPLETION = 2'd2,
        OP_TICK       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_ENTRY      = 2'd0,
        KIND_DOORBELL   = 2'd1,
        KIND_COMPLETION = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TIMEOUT  = 2'd1,
        ERR_DISABLED = 2'd2,
        ERR_BUSY     = 2'd3
    } err_t;

    typedef enum logic [7:0] {
        CFG_ENABLE    = 8'd0,
        CFG_NAMESPACE = 8'd1,
        CFG_STRIDE    = 8'd2,
        CFG_TIMEOUT   = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        enabled;
        logic [31:0] namespace_id;
        logic [3:0]  stride;
        logic [23:0] timeout;
    } cfg_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [63:0] lba;
        logic [16:0] block_count;
        logic [63:0] buffer_address;
        logic [15:0] cq_status;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [8:0]  slot_index;
        logic [31:0] command_dword0;
        logic [31:0] entry_namespace;
        logic [63:0] entry_lba;
        logic [15:0] entry_count_field;
        logic [63:0] entry_buffer;
        logic [18:0] doorbell_offset;
        logic [8:0]  doorbell_value;
        logic [14:0] status_code;
        err_t        error_code;
        logic        last;
    } result_t;

    // Up to two results produced by one item, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } pair_t;

    // Doorbell register offset: base + (2*qid + is_cq) * (4 << stride).
    function automatic logic [18:0] doorbell_at(input logic [3:0] stride, input logic is_cq);
        logic [18:0] spacing;
        logic [1:0]  mult;
        begin
            spacing = 19'd4 << stride;
            mult    = {IO_QID[0], is_cq};
            doorbell_at = DB_BASE + (spacing * {17'd0, mult});
        end
    endfunction

endpackage

// ----- rtl/core/nvme_io_queue_pair_host.sv -----
// Top level of the NVMe I/O queue pair host block.
// Host side of one NVMe I/O queue pair with a single command in flight.
// Input items are read/write requests, completion words seen at the
// completion queue head, and timer ticks. A request yields a submission
// entry (result 0) followed by a tail doorbell write (result 1); a
// completion whose phase bit matches the expected phase yields a
// completion status followed by a head doorbell write. Rejected requests
// and timeouts yield one error result; stray completions and idle ticks
// yield nothing. Rate: the input is registered and processed once the
// result buffer can take its results; the result port delivers one
// result per cycle while m_ready is high. An item with two results holds
// the port longer. A new item is taken while results of the
// previous one are still draining. Configuration writes (index 0 enable,
// 1 namespace, 2 doorbell stride, 3 timeout) are always ready and must only
// be issued while the block is idle; other indexes are ignored.
module nvme_io_queue_pair_host
    import nvqp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request / event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_lba,
    input  logic [16:0] s_block_count,
    input  logic [63:0] s_buffer_address,
    input  logic [15:0] s_cq_status,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [8:0]  m_slot_index,
    output logic [31:0] m_command_dword0,
    output logic [31:0] m_entry_namespace,
    output logic [63:0] m_entry_lba,
    output logic [15:0] m_entry_count_field,
    output logic [63:0] m_entry_buffer,
    output logic [18:0] m_doorbell_offset,
    output logic [8:0]  m_doorbell_value,
    output logic [14:0] m_status_code,
    output logic [1:0]  m_error_code,
    output logic        m_last,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    step;
    logic    pair_ready;
    pair_t   pair;
    result_t m_result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled      <= 1'b0;
            cfg_reg.namespace_id <= '0;
            cfg_reg.stride       <= '0;
            cfg_reg.timeout      <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ENABLE) begin
                cfg_reg.enabled <= cfg_data[0];
            end
            if (cfg_index == CFG_NAMESPACE) begin
                cfg_reg.namespace_id <= cfg_data;
            end
            if (cfg_index == CFG_STRIDE) begin
                cfg_reg.stride <= cfg_data[3:0];
            end
            if (cfg_index == CFG_TIMEOUT) begin
                cfg_reg.timeout <= cfg_data[23:0];
            end
        end
    end

    // input register: refills in the same cycle its item is processed
    assign step    = in_valid_reg && pair_ready;
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.opcode         <= opcode_t'(s_opcode);
            in_item_reg.lba            <= s_lba;
            in_item_reg.block_count    <= s_block_count;
            in_item_reg.buffer_address <= s_buffer_address;
            in_item_reg.cq_status      <= s_cq_status;
        end
    end

    nvqp_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg_reg),
        .step_i  (step),
        .item_i  (in_item_reg),
        .pair_o  (pair)
    );

    nvqp_out_buf u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (step),
        .pair_i       (pair),
        .pair_ready_o (pair_ready),
        .m_valid_o    (m_valid),
        .m_ready_i    (m_ready),
        .m_result_o   (m_result)
    );

    assign m_result_kind       = m_result.kind;
    assign m_slot_index        = m_result.slot_index;
    assign m_command_dword0    = m_result.command_dword0;
    assign m_entry_namespace   = m_result.entry_namespace;
    assign m_entry_lba         = m_result.entry_lba;
    assign m_entry_count_field = m_result.entry_count_field;
    assign m_entry_buffer      = m_result.entry_buffer;
    assign m_doorbell_offset   = m_result.doorbell_offset;
    assign m_doorbell_value    = m_result.doorbell_value;
    assign m_status_code       = m_result.status_code;
    assign m_error_code        = m_result.error_code;
    assign m_last              = m_result.last;

endmodule

// ----- rtl/core/nvqp_engine.sv -----
// Queue state and result formation for one accepted item.
module nvqp_engine
    import nvqp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg_i,
    input  logic  step_i,
    input  item_t item_i,
    output pair_t pair_o
);

    localparam int unsigned PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [PTR_W-1:0] sq_tail_reg, sq_tail_next;
    logic [PTR_W-1:0] cq_head_reg, cq_head_next;
    logic             phase_reg, phase_next;
    logic [15:0]      cmd_id_reg, cmd_id_next;
    logic             waiting_reg, waiting_next;
    logic [23:0]      wait_cnt_reg, wait_cnt_next;

    logic [PTR_W-1:0] tail_inc, head_inc;
    logic [23:0]      wait_inc;
    result_t          r0, r1;

    // Low nine bits of a queue pointer, zero-extended for shallow queues.
    function automatic logic [8:0] to_slot(input logic [PTR_W-1:0] ptr);
        logic [PTR_W+8:0] ext;
        begin
            ext     = {9'd0, ptr};
            to_slot = ext[8:0];
        end
    endfunction

    assign tail_inc = (sq_tail_reg == PTR_LAST) ? '0 : sq_tail_reg + PTR_W'(1);
    assign head_inc = (cq_head_reg == PTR_LAST) ? '0 : cq_head_reg + PTR_W'(1);
    assign wait_inc = wait_cnt_reg + 24'd1;

    always_comb begin
        sq_tail_next  = sq_tail_reg;
        cq_head_next  = cq_head_reg;
        phase_next    = phase_reg;
        cmd_id_next   = cmd_id_reg;
        waiting_next  = waiting_reg;
        wait_cnt_next = wait_cnt_reg;
        r0            = '0;
        r1            = '0;
        pair_o        = '0;

        unique case (item_i.opcode)
            OP_READ, OP_WRITE: begin
                if (!cfg_i.enabled) begin
                    r0.kind       = KIND_ERROR;
                    r0.error_code = ERR_DISABLED;
                    r0.last       = 1'b1;
                    pair_o.count  = 2'd1;
                end else if (waiting_reg) begin
                    r0.kind       = KIND_ERROR;
                    r0.error_code = ERR_BUSY;
                    r0.last       = 1'b1;
                    pair_o.count  = 2'd1;
                end else begin
                    r0.kind              = KIND_ENTRY;
                    r0.slot_index        = to_slot(sq_tail_reg);
                    r0.command_dword0    = {cmd_id_reg, 8'h00,
                        (item_i.opcode == OP_READ) ? NVM_OPC_READ : NVM_OPC_WRITE};
                    r0.entry_namespace   = cfg_i.namespace_id;
                    r0.entry_lba         = item_i.lba;
                    r0.entry_count_field = 16'(item_i.block_count - 17'd1);
                    r0.entry_buffer      = item_i.buffer_address;
                    r1.kind              = KIND_DOORBELL;
                    r1.doorbell_offset   = doorbell_at(cfg_i.stride, 1'b0);
                    r1.doorbell_value    = to_slot(tail_inc);
                    r1.last              = 1'b1;
                    pair_o.count         = 2'd2;
                    sq_tail_next         = tail_inc;
                    waiting_next         = 1'b1;
                    wait_cnt_next        = '0;
                end
            end
            OP_COMPLETION: begin
                if (waiting_reg && (item_i.cq_status[0] == phase_reg)) begin
                    r0.kind            = KIND_COMPLETION;
                    r0.status_code     = item_i.cq_status[15:1];
                    r1.kind            = KIND_DOORBELL;
                    r1.doorbell_offset = doorbell_at(cfg_i.stride, 1'b1);
                    r1.doorbell_value  = to_slot(head_inc);
                    r1.last            = 1'b1;
                    pair_o.count       = 2'd2;
                    cq_head_next       = head_inc;
                    if (head_inc == '0) begin
                        phase_next = ~phase_reg;
                    end
                    cmd_id_next   = cmd_id_reg + 16'd1;
                    waiting_next  = 1'b0;
                    wait_cnt_next = '0;
                end
            end
            OP_TICK: begin
                if (waiting_reg) begin
                    wait_cnt_next = wait_inc;
                    // counter wrap also ends the wait
                    if ((wait_inc >= cfg_i.timeout) || (wait_inc == '0)) begin
                        r0.kind       = KIND_ERROR;
                        r0.error_code = ERR_TIMEOUT;
                        r0.last       = 1'b1;
                        pair_o.count  = 2'd1;
                        waiting_next  = 1'b0;
                        wait_cnt_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        pair_o.first  = r0;
        pair_o.second = r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_tail_reg  <= '0;
            cq_head_reg  <= '0;
            phase_reg    <= 1'b1;
            cmd_id_reg   <= '0;
            waiting_reg  <= 1'b0;
            wait_cnt_reg <= '0;
        end else if (step_i) begin
            sq_tail_reg  <= sq_tail_next;
            cq_head_reg  <= cq_head_next;
            phase_reg    <= phase_next;
            cmd_id_reg   <= cmd_id_next;
            waiting_reg  <= waiting_next;
            wait_cnt_reg <= wait_cnt_next;
        end
    end

endmodule

// ----- rtl/core/nvqp_out_buf.sv -----
// Two-entry result buffer that hands out an item's results in order.
module nvqp_out_buf
    import nvqp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_i,
    input  pair_t   pair_i,
    output logic    pair_ready_o,
    output logic    m_valid_o,
    input  logic    m_ready_i,
    output result_t m_result_o
);

    logic [1:0] count_reg, count_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop;

    assign pop          = (count_reg != 2'd0) && m_ready_i;
    assign pair_ready_o = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready_i);
    assign m_valid_o    = (count_reg != 2'd0);
    assign m_result_o   = head_reg;

    always_comb begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        priority if (push_i && (pair_i.count != 2'd0)) begin
            // push only lands when the buffer is empty or draining its last entry
            head_next  = pair_i.first;
            tail_next  = pair_i.second;
            count_next = pair_i.count;
        end else if (pop) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else begin
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- rtl/core/nvqp_checker.sv -----
// Port-level assertions for the queue pair host, bound to the top level.
module nvqp_checker
    import nvqp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [1:0]  m_error_code,
    input logic [18:0] m_doorbell_offset,
    input logic        m_last
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_doorbell_offset) && $stable(m_last))
        else $error("result changed while stalled");

    // an entry or completion is never marked last, since its doorbell follows
    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_ENTRY || m_result_kind == KIND_COMPLETION)
            |-> !m_last)
        else $error("entry or completion marked last");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_DOORBELL || m_result_kind == KIND_ERROR)
            |-> m_last)
        else $error("doorbell or error not marked last");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_result_kind == KIND_ERROR) == (m_error_code != ERR_NONE)))
        else $error("error code does not match result kind");

endmodule

bind nvme_io_queue_pair_host nvqp_checker u_nvqp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_result_kind     (m_result_kind),
    .m_error_code      (m_error_code),
    .m_doorbell_offset (m_doorbell_offset),
    .m_last            (m_last)
);
